>>> rtl/sdes_pkg.sv
// ----------------------------------------------------------------------------
// sdes_pkg
// Types, permutation tables, s-boxes and round functions for the
// simplified DES block cipher in CBC mode.
// ----------------------------------------------------------------------------
package sdes_pkg;

    typedef logic [9:0] key_t;
    typedef logic [7:0] block_t;
    typedef logic [1:0] reg_idx_t;

    localparam int DATA_W = 32;
    localparam int ADDR_W = 4;

    // register indexes on the configuration port
    localparam reg_idx_t REG_CIPHER_KEY   = 2'd0;
    localparam reg_idx_t REG_INIT_VECTOR  = 2'd1;
    localparam reg_idx_t REG_DECRYPT_MODE = 2'd2;

    // permutation tables, position 1 is the msb
    localparam int P10 [10] = '{3, 5, 2, 7, 4, 10, 1, 9, 8, 6};
    localparam int P8  [8]  = '{6, 3, 7, 4, 8, 5, 10, 9};
    localparam int IP  [8]  = '{2, 6, 3, 1, 4, 8, 5, 7};
    localparam int IPI [8]  = '{4, 1, 3, 5, 7, 2, 8, 6};
    localparam int EP  [8]  = '{4, 1, 2, 3, 2, 3, 4, 1};
    localparam int P4  [4]  = '{2, 4, 3, 1};

    localparam logic [1:0] SBOX0 [4][4] = '{
        '{2'd1, 2'd0, 2'd3, 2'd2},
        '{2'd3, 2'd2, 2'd1, 2'd0},
        '{2'd0, 2'd2, 2'd1, 2'd3},
        '{2'd3, 2'd1, 2'd3, 2'd2}
    };
    localparam logic [1:0] SBOX1 [4][4] = '{
        '{2'd0, 2'd1, 2'd2, 2'd3},
        '{2'd2, 2'd0, 2'd1, 2'd3},
        '{2'd3, 2'd0, 2'd1, 2'd0},
        '{2'd2, 2'd1, 2'd0, 2'd3}
    };

    function automatic key_t perm_p10(input key_t v);
        key_t r;
        for (int i = 0; i < 10; i++)
        begin
            r[9-i] = v[10-P10[i]];
        end
        return r;
    endfunction

    function automatic block_t perm_p8(input key_t v);
        block_t r;
        for (int i = 0; i < 8; i++)
        begin
            r[7-i] = v[10-P8[i]];
        end
        return r;
    endfunction

    function automatic block_t perm_ip(input block_t v);
        block_t r;
        for (int i = 0; i < 8; i++)
        begin
            r[7-i] = v[8-IP[i]];
        end
        return r;
    endfunction

    function automatic block_t perm_ipi(input block_t v);
        block_t r;
        for (int i = 0; i < 8; i++)
        begin
            r[7-i] = v[8-IPI[i]];
        end
        return r;
    endfunction

    function automatic block_t perm_ep(input logic [3:0] v);
        block_t r;
        for (int i = 0; i < 8; i++)
        begin
            r[7-i] = v[4-EP[i]];
        end
        return r;
    endfunction

    function automatic logic [3:0] perm_p4(input logic [3:0] v);
        logic [3:0] r;
        for (int i = 0; i < 4; i++)
        begin
            r[3-i] = v[4-P4[i]];
        end
        return r;
    endfunction

    // k1 after a rotate by one of each half, k2 after a further rotate by two
    function automatic block_t subkey1(input key_t key);
        key_t t;
        t = perm_p10(key);
        return perm_p8({t[8:5], t[9], t[3:0], t[4]});
    endfunction

    function automatic block_t subkey2(input key_t key);
        key_t t;
        t = perm_p10(key);
        return perm_p8({t[6:5], t[9:7], t[1:0], t[4:2]});
    endfunction

    function automatic block_t round_fk(input block_t bits, input block_t key);
        block_t     x;
        logic [3:0] s;
        x = perm_ep(bits[3:0]) ^ key;
        s = {SBOX0[{x[7], x[4]}][{x[6], x[5]}], SBOX1[{x[3], x[0]}][{x[2], x[1]}]};
        return {bits[7:4] ^ perm_p4(s), bits[3:0]};
    endfunction

    function automatic block_t sdes_pass(input block_t blk, input block_t ka,
                                         input block_t kb);
        block_t t;
        t = round_fk(perm_ip(blk), ka);
        t = round_fk({t[3:0], t[7:4]}, kb);
        return perm_ipi(t);
    endfunction

endpackage

>>> rtl/sdes_cbc_block_cipher.sv
// ----------------------------------------------------------------------------
// sdes_cbc_block_cipher
// Simplified DES on 8-bit blocks in CBC mode, with an APB register port for
// key, initialization vector and direction.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  input    in         in_valid / in_stall    data_block, restart_chain
//  output   out        out_valid / out_stall  result_block
//  config   in         psel/penable/pwrite    paddr, pwdata, prdata, pready
//
// one transaction per cycle while out_stall does not hold the result register;
// a block waits in the input register and then sits in the result register
// the cipher and chain update are combinational from input to result register
// reset clears the valid flags, the configuration registers and the chain value
// in_stall rises only while the input register is full and the result
// register is held by out_stall
// ----------------------------------------------------------------------------
module sdes_cbc_block_cipher (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [7:0]                    data_block,
    input  logic                          restart_chain,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [7:0]                    result_block,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sdes_pkg::ADDR_W-1:0]   paddr,
    input  logic [sdes_pkg::DATA_W-1:0]   pwdata,
    output logic [sdes_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import sdes_pkg::*;

    key_t     cipher_key_reg;
    block_t   init_vector_reg;
    logic     decrypt_mode_reg;
    block_t   chain_reg;
    block_t   chain_next;

    logic     in_valid_reg;
    logic     in_valid_next;
    block_t   data_reg;
    logic     restart_reg;
    logic     out_valid_reg;
    logic     out_valid_next;
    block_t   result_reg;
    block_t   result_next;

    logic     accept;
    logic     advance;
    logic     cfg_write;
    reg_idx_t cfg_idx;
    block_t   k1;
    block_t   k2;
    block_t   chain_in;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cipher_key_reg   <= '0;
            init_vector_reg  <= '0;
            decrypt_mode_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                REG_CIPHER_KEY:   cipher_key_reg   <= pwdata[9:0];
                REG_INIT_VECTOR:  init_vector_reg  <= pwdata[7:0];
                REG_DECRYPT_MODE: decrypt_mode_reg <= pwdata[0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_CIPHER_KEY:   prdata = {{(DATA_W-10){1'b0}}, cipher_key_reg};
            REG_INIT_VECTOR:  prdata = {{(DATA_W-8){1'b0}}, init_vector_reg};
            REG_DECRYPT_MODE: prdata = {{(DATA_W-1){1'b0}}, decrypt_mode_reg};
            default:          prdata = '0;
        endcase
    end

    // handshake between the two stages
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = in_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    assign k1       = subkey1(cipher_key_reg);
    assign k2       = subkey2(cipher_key_reg);
    assign chain_in = restart_reg ? init_vector_reg : chain_reg;

    always_comb
    begin
        if (decrypt_mode_reg)
        begin
            result_next = sdes_pass(data_reg, k2, k1) ^ chain_in;
            chain_next  = data_reg;
        end
        else
        begin
            result_next = sdes_pass(data_reg ^ chain_in, k1, k2);
            chain_next  = result_next;
        end
    end

    always_comb
    begin
        in_valid_next  = accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_valid_next = advance ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            chain_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance && in_valid_reg)
            begin
                chain_reg <= chain_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg    <= data_block;
            restart_reg <= restart_chain;
        end
        if (advance && in_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_block = result_reg;

    // stall only while a block is waiting in the input register
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_valid_reg)
        else $error("input stalled with empty input register");

    // a held block is not dropped
    a_hold_block: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && out_valid_reg))
        else $error("held block lost");

    // encryption chains on the ciphertext just produced
    a_chain_enc: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_valid_reg && !decrypt_mode_reg) |=> (chain_reg == result_reg))
        else $error("encrypt chain value differs from result");

    // decryption chains on the incoming ciphertext
    a_chain_dec: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_valid_reg && decrypt_mode_reg) |=> (chain_reg == $past(data_reg)))
        else $error("decrypt chain value differs from input block");

endmodule
